[rtl/core/hcbd_pkg.sv]
// Package with the constants, phase type and helpers of the chunked body deframer.
`timescale 1ns / 1ps
`default_nettype none
package hcbd_pkg;

  localparam int MAX_LINE  = 8192;
  localparam int SIZE_BITS = 32;
  localparam int LINE_W    = $clog2(MAX_LINE);

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;

  typedef enum logic [6:0] {
    PH_SIZE    = 7'b0000001,
    PH_DATA    = 7'b0000010,
    PH_SKIP_A  = 7'b0000100,
    PH_SKIP_B  = 7'b0001000,
    PH_TRAILER = 7'b0010000,
    PH_DONE    = 7'b0100000,
    PH_FAIL    = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t h;
    h.ok = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage
`default_nettype wire

[rtl/core/http_chunked_body_deframer.sv]
// Top level of the chunked HTTP body deframer: parser state and result register.
`timescale 1ns / 1ps
`default_nettype none
// Decodes a chunked HTTP/1.1 body, one byte per input transaction, and returns
// exactly one result transaction per byte: the payload byte with payload_valid,
// chunk_last on the last byte of a chunk, body_done on the byte that ends the
// empty line after the trailers, and a sticky parse_error. The parse step runs
// in the cycle the byte is accepted and lands in the result register, so a new
// byte is accepted every cycle while the result register is empty or being
// taken downstream. Assert start_of_body on the first byte of a body to clear
// the parser, including a latched error.
module http_chunked_body_deframer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] body_byte,
  input  wire logic       start_of_body,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      payload_byte,
  output logic            payload_valid,
  output logic            chunk_last,
  output logic            body_done,
  output logic            parse_error
);

  localparam int SB = hcbd_pkg::SIZE_BITS;
  localparam int LW = hcbd_pkg::LINE_W;

  hcbd_pkg::phase_t phase, phase_next;
  logic [SB-1:0] size_acc, size_acc_next;
  logic [SB-1:0] bytes_remaining, bytes_remaining_next;
  logic [LW-1:0] line_length, line_length_next;
  logic digit_seen, digit_seen_next;
  logic digits_closed, digits_closed_next;
  logic cr_pending, cr_pending_next;
  logic error_flag, error_flag_next;

  logic [7:0] pb_next;
  logic pv_next, cl_next, bd_next;

  logic in_take;
  logic line_end;
  logic line_full;
  logic [LW:0] line_inc;
  hcbd_pkg::hex_t hex;

  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;
  assign hex      = hcbd_pkg::hex_value(body_byte);
  assign line_end = (body_byte == hcbd_pkg::CH_CR) || (body_byte == hcbd_pkg::CH_LF);

  always_comb begin
    phase_next           = phase;
    size_acc_next        = size_acc;
    bytes_remaining_next = bytes_remaining;
    line_length_next     = line_length;
    digit_seen_next      = digit_seen;
    digits_closed_next   = digits_closed;
    cr_pending_next      = cr_pending;
    error_flag_next      = error_flag;
    pb_next = 8'd0;
    pv_next = 1'b0;
    cl_next = 1'b0;
    bd_next = 1'b0;

    // start of body clears the parser before this byte is parsed
    if (start_of_body) begin
      phase_next           = hcbd_pkg::PH_SIZE;
      size_acc_next        = '0;
      bytes_remaining_next = '0;
      line_length_next     = '0;
      digit_seen_next      = 1'b0;
      digits_closed_next   = 1'b0;
      cr_pending_next      = 1'b0;
      error_flag_next      = 1'b0;
    end

    line_inc  = {1'b0, line_length_next} + (LW+1)'(1);
    line_full = line_inc >= (LW+1)'(hcbd_pkg::MAX_LINE);

    if (!error_flag_next) begin
      if (cr_pending_next && body_byte == hcbd_pkg::CH_LF) begin
        // drop the LF that follows a CR
        cr_pending_next = 1'b0;
      end else begin
        cr_pending_next = 1'b0;
        case (phase_next)
          hcbd_pkg::PH_SIZE: begin
            if (line_end) begin
              cr_pending_next  = (body_byte == hcbd_pkg::CH_CR);
              line_length_next = '0;
              if (!digit_seen_next) begin
                error_flag_next = 1'b1;
                phase_next      = hcbd_pkg::PH_FAIL;
              end else begin
                bytes_remaining_next = size_acc_next;
                phase_next = (size_acc_next == '0) ? hcbd_pkg::PH_TRAILER
                                                   : hcbd_pkg::PH_DATA;
                size_acc_next      = '0;
                digit_seen_next    = 1'b0;
                digits_closed_next = 1'b0;
              end
            end else if (line_full) begin
              error_flag_next = 1'b1;
              phase_next      = hcbd_pkg::PH_FAIL;
            end else begin
              line_length_next = line_inc[LW-1:0];
              if (!digits_closed_next) begin
                if (hex.ok) begin
                  // one more digit must not push the size past its width
                  if (size_acc_next[SB-1 -: 4] != 4'd0) begin
                    error_flag_next = 1'b1;
                    phase_next      = hcbd_pkg::PH_FAIL;
                  end else begin
                    size_acc_next   = {size_acc_next[SB-5:0], hex.value};
                    digit_seen_next = 1'b1;
                  end
                end else if ((body_byte == hcbd_pkg::CH_SPACE ||
                              body_byte == hcbd_pkg::CH_TAB) && !digit_seen_next) begin
                  digits_closed_next = 1'b0;
                end else begin
                  digits_closed_next = 1'b1;
                end
              end
            end
          end
          hcbd_pkg::PH_DATA: begin
            pb_next = body_byte;
            pv_next = 1'b1;
            bytes_remaining_next = bytes_remaining_next - SB'(1);
            if (bytes_remaining_next == '0) begin
              cl_next    = 1'b1;
              phase_next = hcbd_pkg::PH_SKIP_A;
            end
          end
          hcbd_pkg::PH_SKIP_A: begin
            phase_next = hcbd_pkg::PH_SKIP_B;
          end
          hcbd_pkg::PH_SKIP_B: begin
            phase_next       = hcbd_pkg::PH_SIZE;
            line_length_next = '0;
          end
          hcbd_pkg::PH_TRAILER: begin
            if (line_end) begin
              cr_pending_next = (body_byte == hcbd_pkg::CH_CR);
              if (line_length_next == '0) begin
                bd_next    = 1'b1;
                phase_next = hcbd_pkg::PH_DONE;
              end
              line_length_next = '0;
            end else if (line_full) begin
              error_flag_next = 1'b1;
              phase_next      = hcbd_pkg::PH_FAIL;
            end else begin
              line_length_next = line_inc[LW-1:0];
            end
          end
          hcbd_pkg::PH_DONE: begin
            phase_next = hcbd_pkg::PH_DONE;
          end
          default: begin
            error_flag_next = 1'b1;
            phase_next      = hcbd_pkg::PH_FAIL;
          end
        endcase
      end
    end

    if (error_flag_next) begin
      pb_next = 8'd0;
      pv_next = 1'b0;
      cl_next = 1'b0;
      bd_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= hcbd_pkg::PH_SIZE;
      size_acc        <= '0;
      bytes_remaining <= '0;
      line_length     <= '0;
      digit_seen      <= 1'b0;
      digits_closed   <= 1'b0;
      cr_pending      <= 1'b0;
      error_flag      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (in_take) begin
        phase           <= phase_next;
        size_acc        <= size_acc_next;
        bytes_remaining <= bytes_remaining_next;
        line_length     <= line_length_next;
        digit_seen      <= digit_seen_next;
        digits_closed   <= digits_closed_next;
        cr_pending      <= cr_pending_next;
        error_flag      <= error_flag_next;
        out_valid       <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload: load on every accepted transaction, hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      payload_byte  <= pb_next;
      payload_valid <= pv_next;
      chunk_last    <= cl_next;
      body_done     <= bd_next;
      parse_error   <= error_flag_next;
    end
  end

`ifndef SYNTH
  a_err_phase: assert property (@(posedge clk) disable iff (rst)
    error_flag == (phase == hcbd_pkg::PH_FAIL))
    else $error("error flag and fail phase disagree");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (in_take && error_flag && !start_of_body) |=> (out_valid && parse_error))
    else $error("latched error not reported");

  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && parse_error) |-> !(payload_valid || chunk_last || body_done))
    else $error("result fields set alongside error");

  a_last_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && chunk_last) |-> (payload_valid && !body_done))
    else $error("chunk_last without payload");

  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    (in_take && bd_next) |=> (phase == hcbd_pkg::PH_DONE))
    else $error("body_done without done phase");
`endif

endmodule
`default_nettype wire
